// ----- design/mvsi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor valve safety interlock package
// Command codes, safety state codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package mvsi_pkg;

  typedef enum logic [1:0] {
    OP_EVALUATE    = 2'd0,
    OP_CLEAR_FAULT = 2'd1,
    OP_RESET_CYCLE = 2'd2,
    OP_RESERVED    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_NORMAL      = 3'd0,
    ST_FAULT       = 3'd1,
    ST_OC_LOCKED   = 3'd2,
    ST_OC          = 3'd3,
    ST_TIMEOUT     = 3'd4,
    ST_LOW_BATT    = 3'd5,
    ST_CUT_PENDING = 3'd6
  } safety_state_e;

  typedef enum logic [1:0] {
    REG_CRITICAL_VOLTAGE = 2'd0,
    REG_OVERCURRENT_TRIP = 2'd1,
    REG_MAX_RUNTIME      = 2'd2,
    REG_UNUSED           = 2'd3
  } reg_index_e;

  localparam logic [15:0] CRITICAL_VOLTAGE_RESET = 16'd10500;
  localparam logic [15:0] OVERCURRENT_TRIP_RESET = 16'd2000;
  localparam logic [31:0] MAX_RUNTIME_RESET      = 32'd30000;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] now_ms;
    logic        motor_on;
    logic        voltage_ok;
    logic        voltage_lockout;
    logic [15:0] bus_voltage_mv;
    logic        overcurrent_flag;
    logic        overcurrent_lockout;
    logic        current_ok;
    logic [15:0] motor_current_ma;
    logic        bypass_request;
    logic        bypass_ack;
  } in_item_t;

  typedef struct packed {
    safety_state_e safety_state;
    logic          stop_request;
    logic          close_request;
    logic          start_allowed;
    logic          run_allowed;
    logic          bypass_needed;
    logic          fault_flag;
    logic          latched_now;
    logic [31:0]   runtime_ms;
  } result_t;

endpackage

// ----- design/motor_valve_safety_interlock.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor valve safety interlock
// Evaluates voltage, current and runtime against a fixed priority and issues
// stop/close/start/run permissions, keeping a fault latch and run timer.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while in_stall_o is low and
// returns exactly one result per request: the request is captured in an
// input register, evaluated by one short pass of priority logic (one 32-bit
// wrapping subtraction for the runtime and a few compares), and the result
// lands in an output register. Interlock state (fault latch, safety mode, run
// start time, timing flag) updates in the same cycle the request moves into
// the output register, so the next request sees it immediately. A stall on
// the output holds the output register and any request waiting in the input
// register, raising in_stall_o in the same cycle. Registers are written
// through cfg_we_i / cfg_index_i / cfg_data_i and must only change while no
// request is in flight; an index beyond the three registers is ignored.
// ----------------------------------------------------------------------------
module motor_valve_safety_interlock (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] now_ms_i,
  input  logic        motor_on_i,
  input  logic        voltage_ok_i,
  input  logic        voltage_lockout_i,
  input  logic [15:0] bus_voltage_mv_i,
  input  logic        overcurrent_flag_i,
  input  logic        overcurrent_lockout_i,
  input  logic        current_ok_i,
  input  logic [15:0] motor_current_ma_i,
  input  logic        bypass_request_i,
  input  logic        bypass_ack_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  safety_state_o,
  output logic        stop_request_o,
  output logic        close_request_o,
  output logic        start_allowed_o,
  output logic        run_allowed_o,
  output logic        bypass_needed_o,
  output logic        fault_flag_o,
  output logic        latched_now_o,
  output logic [31:0] runtime_ms_o
);

  // Configuration registers
  logic [15:0] crit_mv_q;
  logic [15:0] oc_trip_q;
  logic [31:0] max_rt_q;

  // Interlock state
  logic                   fault_latch_q, fault_latch_d;
  mvsi_pkg::safety_state_e mode_q, mode_d;
  logic [31:0]            run_start_q, run_start_d;
  logic                   timing_active_q, timing_active_d;

  // Pipeline registers
  logic                 s1_valid_q;
  mvsi_pkg::in_item_t   s1_q;
  logic                 out_valid_q;
  mvsi_pkg::result_t    res_q, res_d;

  logic s1_adv;
  logic in_take;

  // Output register frees up when empty or drained this cycle; the input
  // register advances into it then.
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // Configuration write port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crit_mv_q <= mvsi_pkg::CRITICAL_VOLTAGE_RESET;
      oc_trip_q <= mvsi_pkg::OVERCURRENT_TRIP_RESET;
      max_rt_q  <= mvsi_pkg::MAX_RUNTIME_RESET;
    end else if (cfg_we_i) begin
      unique case (mvsi_pkg::reg_index_e'(cfg_index_i))
        mvsi_pkg::REG_CRITICAL_VOLTAGE: crit_mv_q <= cfg_data_i[15:0];
        mvsi_pkg::REG_OVERCURRENT_TRIP: oc_trip_q <= cfg_data_i[15:0];
        mvsi_pkg::REG_MAX_RUNTIME:      max_rt_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q.operation           <= operation_i;
      s1_q.now_ms              <= now_ms_i;
      s1_q.motor_on            <= motor_on_i;
      s1_q.voltage_ok          <= voltage_ok_i;
      s1_q.voltage_lockout     <= voltage_lockout_i;
      s1_q.bus_voltage_mv      <= bus_voltage_mv_i;
      s1_q.overcurrent_flag    <= overcurrent_flag_i;
      s1_q.overcurrent_lockout <= overcurrent_lockout_i;
      s1_q.current_ok          <= current_ok_i;
      s1_q.motor_current_ma    <= motor_current_ma_i;
      s1_q.bypass_request      <= bypass_request_i;
      s1_q.bypass_ack          <= bypass_ack_i;
    end
  end

  // --------------------------------------------------------------------------
  // Evaluation pass
  // --------------------------------------------------------------------------
  logic [31:0] runtime;
  logic        running;

  assign running = s1_q.motor_on;
  // A run that starts on this request reports zero elapsed time.
  assign runtime = timing_active_q ? (s1_q.now_ms - run_start_q) : 32'd0;

  always_comb begin
    fault_latch_d   = fault_latch_q;
    mode_d          = mode_q;
    run_start_d     = run_start_q;
    timing_active_d = timing_active_q;
    res_d           = '0;

    unique case (mvsi_pkg::op_e'(s1_q.operation))
      mvsi_pkg::OP_CLEAR_FAULT: begin
        fault_latch_d   = 1'b0;
        mode_d          = mvsi_pkg::ST_NORMAL;
        run_start_d     = '0;
        timing_active_d = 1'b0;
      end
      mvsi_pkg::OP_RESET_CYCLE: begin
        run_start_d     = '0;
        timing_active_d = 1'b0;
        if (!fault_latch_q) begin
          mode_d = mvsi_pkg::ST_NORMAL;
        end
      end
      mvsi_pkg::OP_EVALUATE: begin
        if (fault_latch_q) begin
          // Latched fault: hold timing, report fault and request a stop if running.
          mode_d             = mvsi_pkg::ST_FAULT;
          res_d.stop_request = running;
          res_d.fault_flag   = 1'b1;
        end else begin
          // Advance or drop the run timer.
          if (running) begin
            if (!timing_active_q) begin
              run_start_d     = s1_q.now_ms;
              timing_active_d = 1'b1;
            end
            res_d.runtime_ms = runtime;
          end else begin
            run_start_d     = '0;
            timing_active_d = 1'b0;
          end

          priority if (!s1_q.voltage_ok) begin
            fault_latch_d      = 1'b1;
            mode_d             = mvsi_pkg::ST_FAULT;
            res_d.stop_request = running;
            res_d.fault_flag   = 1'b1;
          end else if (s1_q.voltage_lockout || (s1_q.bus_voltage_mv < crit_mv_q)) begin
            fault_latch_d       = 1'b1;
            mode_d              = mvsi_pkg::ST_FAULT;
            res_d.stop_request  = running;
            res_d.close_request = running;
            res_d.fault_flag    = 1'b1;
          end else if (s1_q.overcurrent_lockout || (s1_q.overcurrent_flag && running)) begin
            if (s1_q.overcurrent_lockout) begin
              mode_d        = mvsi_pkg::ST_OC_LOCKED;
              fault_latch_d = 1'b1;
            end else begin
              mode_d = mvsi_pkg::ST_OC;
            end
            res_d.stop_request = 1'b1;
            res_d.fault_flag   = s1_q.overcurrent_lockout;
          end else if (running && s1_q.current_ok &&
                       (s1_q.motor_current_ma >= oc_trip_q)) begin
            mode_d             = mvsi_pkg::ST_OC;
            res_d.stop_request = 1'b1;
          end else if (running && (runtime >= max_rt_q)) begin
            // Runtime is zero on the request that starts a run, since timing is not yet active.
            fault_latch_d       = 1'b1;
            mode_d              = mvsi_pkg::ST_TIMEOUT;
            res_d.stop_request  = 1'b1;
            res_d.close_request = 1'b1;
            res_d.fault_flag    = 1'b1;
          end else if (s1_q.bypass_request) begin
            res_d.bypass_needed = 1'b1;
            mode_d              = s1_q.bypass_ack ? mvsi_pkg::ST_LOW_BATT
                                                  : mvsi_pkg::ST_CUT_PENDING;
            res_d.run_allowed   = 1'b1;
          end else begin
            mode_d              = mvsi_pkg::ST_NORMAL;
            res_d.start_allowed = 1'b1;
            res_d.run_allowed   = 1'b1;
          end
        end
      end
      default: ;  // reserved code: no change
    endcase

    res_d.safety_state = mode_d;
    res_d.latched_now  = fault_latch_d;
  end

  // --------------------------------------------------------------------------
  // State and result registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_latch_q   <= 1'b0;
      mode_q          <= mvsi_pkg::ST_NORMAL;
      run_start_q     <= '0;
      timing_active_q <= 1'b0;
    end else if (s1_adv) begin
      fault_latch_q   <= fault_latch_d;
      mode_q          <= mode_d;
      run_start_q     <= run_start_d;
      timing_active_q <= timing_active_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign safety_state_o  = res_q.safety_state;
  assign stop_request_o  = res_q.stop_request;
  assign close_request_o = res_q.close_request;
  assign start_allowed_o = res_q.start_allowed;
  assign run_allowed_o   = res_q.run_allowed;
  assign bypass_needed_o = res_q.bypass_needed;
  assign fault_flag_o    = res_q.fault_flag;
  assign latched_now_o   = res_q.latched_now;
  assign runtime_ms_o    = res_q.runtime_ms;

`ifndef NO_ASSERTIONS
  // A reported fault always leaves the latch set.
  a_fault_latches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fault_flag_o |-> latched_now_o)
    else $error("fault reported without latch");

  // Start permission and stop request are mutually exclusive.
  a_start_vs_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(start_allowed_o && stop_request_o))
    else $error("start allowed while stop requested");

  // Bypass keeps the motor running.
  a_bypass_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bypass_needed_o |-> run_allowed_o && !stop_request_o)
    else $error("bypass without run permission");

  // Only a clear-fault request drops the latch.
  a_latch_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_latch_q && !(s1_adv && (s1_q.operation == mvsi_pkg::OP_CLEAR_FAULT))
    |=> fault_latch_q)
    else $error("fault latch dropped without clear");

  // Input register never overwritten while it holds an unmoved request.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_q))
    else $error("input register lost a request");
`endif

endmodule
